FILE: rtl/psic_pkg.sv
// Package for the primitive survivor intersection counter.
// Widths, counter codes, the shared-unit request/response types and helper functions.
// No dependencies.
package psic_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_LOG_WIDTH = 16;
  localparam int CNT_BITS      = 48;
  localparam int LOG_W         = 5;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int POS_W         = WORD_BITS + BIT_W;
  localparam int OFF_W         = MAX_LOG_WIDTH;
  localparam int GCD_W         = 32;
  localparam int PCNT_W        = $clog2(WORD_BITS + 1);
  localparam int N_CNT         = 6;

  // counter slots
  localparam int C_A    = 0;
  localparam int C_B    = 1;
  localparam int C_BOTH = 2;
  localparam int P_A    = 3;
  localparam int P_B    = 4;
  localparam int P_BOTH = 5;

  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic             start;
    logic [GCD_W-1:0] a;
    logic [GCD_W-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic done;
    logic prim;
  } gcd_rsp_t;

  function automatic logic [PCNT_W-1:0] popcnt(input word_t w);
    logic [PCNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      n = n + PCNT_W'(w[k]);
    end
    return n;
  endfunction

  function automatic cnt_t sat_add(input cnt_t c, input logic [PCNT_W-1:0] n);
    logic [CNT_BITS:0] s;
    s = {1'b0, c} + (CNT_BITS+1)'(n);
    return s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
  endfunction

endpackage

FILE: rtl/psic_gcd.sv
// Iterative binary gcd unit: answers whether gcd(a, b) equals one.
// One shift or one compare-and-subtract per cycle. Uses psic_pkg.
module psic_gcd (
  input  logic               clk,
  input  logic               rst_n,
  input  psic_pkg::gcd_req_t req,
  output psic_pkg::gcd_rsp_t rsp
);
  import psic_pkg::*;

  logic             busy_r, busy_nxt;
  logic [GCD_W-1:0] a_r, a_nxt;
  logic [GCD_W-1:0] b_r, b_nxt;

  always_comb begin
    rsp      = '0;
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (busy_r) begin
      if (a_r == '0 || b_r == '0) begin
        // gcd(x, 0) = x
        rsp.done = 1'b1;
        rsp.prim = ((a_r | b_r) == GCD_W'(1));
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        // common factor two; only possible on the first step
        rsp.done = 1'b1;
        busy_nxt = 1'b0;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r == b_r) begin
        rsp.done = 1'b1;
        rsp.prim = (a_r == GCD_W'(1));
        busy_nxt = 1'b0;
      end else if (a_r > b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
    if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("gcd started while busy");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> busy_r) else $error("gcd done without a job");

  a_keep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !rsp.done |=> busy_r) else $error("gcd dropped a job");

endmodule

FILE: rtl/primitive_survivor_intersection_count_core.sv
// Top level of the primitive survivor intersection counter.
// Sequencer, counters and output register; instantiates psic_gcd. Uses psic_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one beat per pair of 32-bit survivor
//   words, side A and side B, in position order. in_start_of_run clears the word
//   index and all six counters before that beat is counted.
//   Output channel (out_valid/out_ready) returns one beat per input beat with the
//   running word count and the six 48-bit saturating totals.
//   cfg_we/cfg_wdata write log_i (log2 of row width, 0 disables the gcd filter);
//   write it only while the block is idle.
//   Timing: the popcounts are added in the accept cycle. With log_i = 0 the scan
//   state goes straight to the done state, which sets out_valid. Otherwise a scan visits
//   the 32 bit positions, one per cycle while no gcd run holds it, and each set bit of A|B
//   waits in the gcd state for the answer of the shared binary gcd unit (one shift or
//   subtract per cycle); the done state then loads the output register and sets out_valid.
//   in_ready is high only while the sequencer is idle; an unread result sits in
//   the output register while the next beat is accepted and processed.
//   If the receiver stalls, the finished totals wait until the register is free.
//   Reset (rst_n low, synchronous) clears log_i, the word index and the counters.
module primitive_survivor_intersection_count_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psic_pkg::LOG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [psic_pkg::WORD_BITS-1:0] in_side_a_word,
  input  logic [psic_pkg::WORD_BITS-1:0] in_side_b_word,
  input  logic                           in_start_of_run,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [psic_pkg::WORD_BITS-1:0] out_words_seen,
  output logic [psic_pkg::CNT_BITS-1:0]  out_count_a,
  output logic [psic_pkg::CNT_BITS-1:0]  out_count_b,
  output logic [psic_pkg::CNT_BITS-1:0]  out_count_both,
  output logic [psic_pkg::CNT_BITS-1:0]  out_primitive_a,
  output logic [psic_pkg::CNT_BITS-1:0]  out_primitive_b,
  output logic [psic_pkg::CNT_BITS-1:0]  out_primitive_both
);
  import psic_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_GCD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LOG_W-1:0] log_i_r, log_i_nxt;
  logic [LOG_W-1:0] lg_r, lg_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  word_t            wa_r, wa_nxt;
  word_t            wb_r, wb_nxt;
  word_t            wi_r, wi_nxt;
  cnt_t             cnt_r [N_CNT];
  cnt_t             cnt_nxt [N_CNT];
  logic             out_valid_r, out_valid_nxt;
  word_t            out_words_r, out_words_nxt;
  cnt_t             out_cnt_r [N_CNT];
  cnt_t             out_cnt_nxt [N_CNT];

  gcd_req_t         gcd_req;
  gcd_rsp_t         gcd_rsp;

  word_t            mask_or;
  logic [LOG_W-1:0] lg_clamp;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_shr;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] half;
  logic [OFF_W-1:0] ai;
  word_t            wi_inc;
  cnt_t             base [N_CNT];
  word_t            wi_base;

  psic_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gcd_req),
    .rsp   (gcd_rsp)
  );

  assign mask_or  = wa_r | wb_r;
  assign lg_clamp = (log_i_r > LOG_W'(MAX_LOG_WIDTH)) ? LOG_W'(MAX_LOG_WIDTH) : log_i_r;

  // position of the current bit and its (i, j) mapping
  assign pos     = {wi_r, bit_r};
  assign pos_shr = pos >> lg_r;
  assign off     = pos[OFF_W-1:0] & ~({OFF_W{1'b1}} << lg_r);
  assign half    = OFF_W'(1) << (lg_r - LOG_W'(1));
  assign ai      = (off >= half) ? (off - half) : (half - off);
  assign wi_inc  = (wi_r != {WORD_BITS{1'b1}}) ? (wi_r + WORD_BITS'(1)) : wi_r;

  assign in_ready = (state_r == S_IDLE);
  assign wi_base  = in_start_of_run ? '0 : wi_r;

  always_comb begin
    for (int k = 0; k < N_CNT; k++) begin
      base[k] = in_start_of_run ? '0 : cnt_r[k];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    log_i_nxt     = log_i_r;
    lg_nxt        = lg_r;
    bit_nxt       = bit_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    wi_nxt        = wi_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_words_nxt = out_words_r;
    out_cnt_nxt   = out_cnt_r;
    gcd_req.start = 1'b0;
    gcd_req.a     = GCD_W'(ai);
    gcd_req.b     = GCD_W'(pos_shr[WORD_BITS-1:0]);

    if (cfg_we) begin
      log_i_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wa_nxt          = in_side_a_word;
          wb_nxt          = in_side_b_word;
          lg_nxt          = lg_clamp;
          bit_nxt         = '0;
          wi_nxt          = wi_base;
          cnt_nxt         = base;
          cnt_nxt[C_A]    = sat_add(base[C_A], popcnt(in_side_a_word));
          cnt_nxt[C_B]    = sat_add(base[C_B], popcnt(in_side_b_word));
          cnt_nxt[C_BOTH] = sat_add(base[C_BOTH], popcnt(in_side_a_word & in_side_b_word));
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (lg_r == '0) begin
          state_nxt = S_DONE;
        end else if (mask_or[bit_r]) begin
          gcd_req.start = 1'b1;
          state_nxt     = S_GCD;
        end else if (bit_r == BIT_W'(WORD_BITS-1)) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r + BIT_W'(1);
        end
      end
      S_GCD: begin
        if (gcd_rsp.done) begin
          if (gcd_rsp.prim) begin
            cnt_nxt[P_A]    = sat_add(cnt_r[P_A], PCNT_W'(wa_r[bit_r]));
            cnt_nxt[P_B]    = sat_add(cnt_r[P_B], PCNT_W'(wb_r[bit_r]));
            cnt_nxt[P_BOTH] = sat_add(cnt_r[P_BOTH], PCNT_W'(wa_r[bit_r] & wb_r[bit_r]));
          end
          if (bit_r == BIT_W'(WORD_BITS-1)) begin
            state_nxt = S_DONE;
          end else begin
            bit_nxt   = bit_r + BIT_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          wi_nxt        = wi_inc;
          out_words_nxt = wi_inc;
          out_cnt_nxt   = cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      log_i_r     <= '0;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < N_CNT; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      log_i_r     <= log_i_nxt;
      wi_r        <= wi_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    lg_r        <= lg_nxt;
    bit_r       <= bit_nxt;
    wa_r        <= wa_nxt;
    wb_r        <= wb_nxt;
    out_words_r <= out_words_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_words_seen     = out_words_r;
  assign out_count_a        = out_cnt_r[C_A];
  assign out_count_b        = out_cnt_r[C_B];
  assign out_count_both     = out_cnt_r[C_BOTH];
  assign out_primitive_a    = out_cnt_r[P_A];
  assign out_primitive_b    = out_cnt_r[P_B];
  assign out_primitive_both = out_cnt_r[P_BOTH];

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SCAN) else $error("beat accepted but no scan");

  a_gcd_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_rsp.done |-> state_r == S_GCD) else $error("gcd answer outside gcd wait");

  a_words_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_words_seen != '0) else $error("result with zero word count");

  a_prim_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_primitive_a <= out_count_a && out_primitive_b <= out_count_b &&
                  out_primitive_both <= out_primitive_a)
    else $error("primitive count exceeds total");

endmodule

FILE: test/primitive_survivor_intersection_count_core_test.sv
// Self-checking bench for primitive_survivor_intersection_count_core: directed and random
// survivor word pairs over several log_i settings, checked against a running-tally model.
// Depends on psic_pkg and the core RTL.
module primitive_survivor_intersection_count_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 10_000_000;

  typedef struct packed {
    psic_pkg::word_t words_seen;
    psic_pkg::cnt_t  count_a;
    psic_pkg::cnt_t  count_b;
    psic_pkg::cnt_t  count_both;
    psic_pkg::cnt_t  prim_a;
    psic_pkg::cnt_t  prim_b;
    psic_pkg::cnt_t  prim_both;
  } survey_totals_t;

  // Running tally of survivors and primitive positions, one expected beat per input beat.
  class survivor_tally_model;
    logic [psic_pkg::LOG_W-1:0] log_width;
    psic_pkg::word_t            word_pos;
    psic_pkg::cnt_t             counts[psic_pkg::N_CNT];
    survey_totals_t             expected_totals[$];
    int                         failures;

    function new();
      log_width = '0;
      word_pos  = '0;
      foreach (counts[k]) counts[k] = '0;
      failures  = 0;
    endfunction

    function void set_log_width(logic [psic_pkg::LOG_W-1:0] v);
      log_width = v;
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction

    function bit [31:0] euclid_gcd(bit [31:0] a, bit [31:0] b);
      bit [31:0] r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    function void bump(int k, int n);
      psic_pkg::cnt_t full;
      full = '1;
      if (counts[k] > full - psic_pkg::cnt_t'(n)) counts[k] = full;
      else counts[k] = counts[k] + psic_pkg::cnt_t'(n);
    endfunction

    function void note_input(psic_pkg::word_t a, psic_pkg::word_t b, bit start);
      psic_pkg::word_t both, span, j, ai_abs;
      int              lg;
      logic [63:0]     pos, off, half;
      survey_totals_t  t;
      both = a & b;
      span = a | b;
      if (start) begin
        word_pos = '0;
        foreach (counts[k]) counts[k] = '0;
      end
      lg = (log_width > psic_pkg::MAX_LOG_WIDTH) ? psic_pkg::MAX_LOG_WIDTH : int'(log_width);
      bump(psic_pkg::C_A, $countones(a));
      bump(psic_pkg::C_B, $countones(b));
      bump(psic_pkg::C_BOTH, $countones(both));
      if (lg != 0) begin
        for (int k = 0; k < psic_pkg::WORD_BITS; k++) begin
          if (span[k]) begin
            pos    = {32'b0, word_pos} * 64'd32 + 64'(k);
            j      = psic_pkg::word_t'(pos >> lg);
            off    = pos & ((64'd1 << lg) - 64'd1);
            half   = 64'd1 << (lg - 1);
            ai_abs = psic_pkg::word_t'(off >= half ? off - half : half - off);
            if (euclid_gcd(ai_abs, j) == 32'd1) begin
              if (a[k])    bump(psic_pkg::P_A, 1);
              if (b[k])    bump(psic_pkg::P_B, 1);
              if (both[k]) bump(psic_pkg::P_BOTH, 1);
            end
          end
        end
      end
      if (word_pos != '1) word_pos = word_pos + 1'b1;
      t.words_seen = word_pos;
      t.count_a    = counts[psic_pkg::C_A];
      t.count_b    = counts[psic_pkg::C_B];
      t.count_both = counts[psic_pkg::C_BOTH];
      t.prim_a     = counts[psic_pkg::P_A];
      t.prim_b     = counts[psic_pkg::P_B];
      t.prim_both  = counts[psic_pkg::P_BOTH];
      expected_totals.push_back(t);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(survey_totals_t got);
      survey_totals_t want;
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual words_seen %0h",
                 $time, got.words_seen);
        failures++;
        return;
      end
      want = expected_totals.pop_front();
      compare_field("words_seen", 64'(want.words_seen), 64'(got.words_seen));
      compare_field("count_a", 64'(want.count_a), 64'(got.count_a));
      compare_field("count_b", 64'(want.count_b), 64'(got.count_b));
      compare_field("count_both", 64'(want.count_both), 64'(got.count_both));
      compare_field("primitive_a", 64'(want.prim_a), 64'(got.prim_a));
      compare_field("primitive_b", 64'(want.prim_b), 64'(got.prim_b));
      compare_field("primitive_both", 64'(want.prim_both), 64'(got.prim_both));
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [psic_pkg::LOG_W-1:0]       cfg_wdata;
  logic                             in_valid;
  logic                             in_ready;
  psic_pkg::word_t                  in_side_a_word;
  psic_pkg::word_t                  in_side_b_word;
  logic                             in_start_of_run;
  logic                             out_valid;
  logic                             out_ready;
  psic_pkg::word_t                  out_words_seen;
  psic_pkg::cnt_t                   out_count_a;
  psic_pkg::cnt_t                   out_count_b;
  psic_pkg::cnt_t                   out_count_both;
  psic_pkg::cnt_t                   out_primitive_a;
  psic_pkg::cnt_t                   out_primitive_b;
  psic_pkg::cnt_t                   out_primitive_both;

  survivor_tally_model tally;
  bit                  rx_quiet;
  int                  rx_stall_left;

  primitive_survivor_intersection_count_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_side_a_word    (in_side_a_word),
    .in_side_b_word    (in_side_b_word),
    .in_start_of_run   (in_start_of_run),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_words_seen    (out_words_seen),
    .out_count_a       (out_count_a),
    .out_count_b       (out_count_b),
    .out_count_both    (out_count_both),
    .out_primitive_a   (out_primitive_a),
    .out_primitive_b   (out_primitive_b),
    .out_primitive_both(out_primitive_both)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // input beats go into the tally on the edge they are taken
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      tally.note_input(in_side_a_word, in_side_b_word, in_start_of_run);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tally.check_result('{out_words_seen, out_count_a, out_count_b, out_count_both,
                           out_primitive_a, out_primitive_b, out_primitive_both});
  end

  // receiver back-pressure: mostly short stalls, a few long, with quiet stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_quiet = ~rx_quiet;
    if (rx_stall_left > 0) begin
      out_ready = 1'b0;
      rx_stall_left--;
    end else if (rx_quiet) begin
      out_ready = 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          out_ready = 1'b0;
          rx_stall_left = $urandom_range(0, 2);
        end
        4: begin
          out_ready = 1'b0;
          rx_stall_left = $urandom_range(20, 60);
        end
        default: out_ready = 1'b1;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sparse words dominate: every set bit costs a gcd run when the filter is on
  function automatic psic_pkg::word_t random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom & $urandom & $urandom;
    if (r < 80) return $urandom & $urandom;
    if (r < 90) return $urandom;
    if (r < 95) return '0;
    return '1;
  endfunction

  task automatic send_beat(psic_pkg::word_t a, psic_pkg::word_t b, bit start, int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_side_a_word  = a;
    in_side_b_word  = b;
    in_start_of_run = start;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_until_settled();
    @(negedge clk) in_valid = 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_log_width(logic [psic_pkg::LOG_W-1:0] v);
    wait_until_settled();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk) cfg_we = 1'b0;
    tally.set_log_width(v);
  endtask

  task automatic random_phase(logic [psic_pkg::LOG_W-1:0] lw, int beats);
    psic_pkg::word_t a, b;
    bit              burst;
    write_log_width(lw);
    burst = ($urandom_range(0, 2) == 0);
    for (int n = 0; n < beats; n++) begin
      a = random_word();
      b = ($urandom_range(0, 2) == 0) ? a ^ ($urandom & $urandom & $urandom) : random_word();
      send_beat(a, b, (n == 0) || ($urandom_range(0, 24) == 0), burst ? 0 : pick_gap());
    end
  endtask

  initial begin
    logic [psic_pkg::LOG_W-1:0] phase_logs[7];
    tally           = new();
    rx_quiet        = 1'b0;
    rx_stall_left   = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_side_a_word  = '0;
    in_side_b_word  = '0;
    in_start_of_run = 1'b0;
    out_ready       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // filter off after reset: primitive totals stay at zero
    send_beat(32'h0000_0000, 32'h0000_0000, 1'b1, 0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 2);
    send_beat(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1);

    // row width 2: j = 0 with |i| = 1 and i = 0 with j = 1 both show up early
    write_log_width(5'd1);
    send_beat(32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b1, 0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
    send_beat(32'h8000_0001, 32'h8000_0001, 1'b0, 3);

    write_log_width(5'd2);
    send_beat(32'hFFFF_FFFF, 32'hF0F0_F0F0, 1'b1, 0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
    send_beat(32'h0000_0000, 32'h0000_0000, 1'b0, 0);

    write_log_width(psic_pkg::MAX_LOG_WIDTH);
    send_beat(32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 0);
    send_beat(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0);

    // oversized settings clamp to the maximum row width
    write_log_width(5'd31);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
    send_beat(32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, 0);
    write_log_width(5'd17);
    send_beat(32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, 0);

    write_log_width(5'd5);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
    send_beat(32'hC3C3_C3C3, 32'h3C3C_3C3C, 1'b0, 0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
    // no start flag: counting carries on across the setting change
    write_log_width(5'd3);
    send_beat(32'h0101_0101, 32'h8080_8080, 1'b0, 0);

    phase_logs = '{5'd0, psic_pkg::MAX_LOG_WIDTH, 5'd1, 5'd31,
                   5'($urandom_range(1, 16)), 5'($urandom_range(2, 12)),
                   5'($urandom_range(0, 31))};
    foreach (phase_logs[p]) random_phase(phase_logs[p], 100);

    wait_until_settled();
    repeat (20) @(posedge clk);
    if (tally.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
